// File: hw/rtl/rpa_pkg.sv
package rpa_pkg;

   // pool and scratch list limits
   localparam int MAX_REGS    = 64;
   localparam int MAX_SCRATCH = 16;
   localparam int REG_IDX_W   = $clog2(MAX_REGS);
   localparam int POOL_W      = 7;
   localparam int SCR_IDX_W   = $clog2(MAX_SCRATCH);
   localparam int SCR_LEN_W   = 5;
   localparam int SCR_ENTRY_W = 8;

   localparam logic [7:0] DEFAULT_SLOT = 8'd8;

   // request opcodes
   localparam logic [2:0] OP_INIT     = 3'd0;
   localparam logic [2:0] OP_ALLOC    = 3'd1;
   localparam logic [2:0] OP_ALLOC_AT = 3'd2;
   localparam logic [2:0] OP_FREE     = 3'd3;
   localparam logic [2:0] OP_QUERY    = 3'd4;
   localparam logic [2:0] OP_RESERVE  = 3'd5;
   localparam logic [2:0] OP_SPILL    = 3'd6;

   // csr register indexes (byte address = 8 * index)
   localparam logic [2:0] CSR_REGISTER_TOTAL     = 3'd0;
   localparam logic [2:0] CSR_SCRATCH_ORDER_LOW  = 3'd1;
   localparam logic [2:0] CSR_SCRATCH_ORDER_HIGH = 3'd2;
   localparam logic [2:0] CSR_SCRATCH_LENGTH     = 3'd3;
   localparam logic [2:0] CSR_RESERVED_MASK      = 3'd4;
   localparam logic [2:0] CSR_FRAME_REG          = 3'd5;
   localparam logic [2:0] CSR_STACK_REG          = 3'd6;
   localparam logic [2:0] CSR_SLOT_SIZE          = 3'd7;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] reg_index;
   } req_type;

   typedef struct packed {
      logic               success;
      logic [7:0]         reg_out;
      logic signed [31:0] slot_offset;
      logic [15:0]        spill_total;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  register_total;
      logic [63:0] scratch_order_low;
      logic [63:0] scratch_order_high;
      logic [4:0]  scratch_length;
      logic [63:0] reserved_mask;
      logic [7:0]  frame_reg;
      logic [7:0]  stack_reg;
      logic [7:0]  slot_size;
   } cfg_type;

endpackage

// File: hw/rtl/rpa_csr.sv
module rpa_csr import rpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [2:0] csr_idx;
   logic       wr_en;

   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.register_total     <= '0;
         cfg_ff.scratch_order_low  <= '0;
         cfg_ff.scratch_order_high <= '0;
         cfg_ff.scratch_length     <= '0;
         cfg_ff.reserved_mask      <= '0;
         cfg_ff.frame_reg          <= 8'd255;
         cfg_ff.stack_reg          <= 8'd255;
         cfg_ff.slot_size          <= DEFAULT_SLOT;
      end else if (wr_en) begin
         case (csr_idx)
            CSR_REGISTER_TOTAL:     cfg_ff.register_total     <= csr_pwdata[6:0];
            CSR_SCRATCH_ORDER_LOW:  cfg_ff.scratch_order_low  <= csr_pwdata;
            CSR_SCRATCH_ORDER_HIGH: cfg_ff.scratch_order_high <= csr_pwdata;
            CSR_SCRATCH_LENGTH:     cfg_ff.scratch_length     <= csr_pwdata[4:0];
            CSR_RESERVED_MASK:      cfg_ff.reserved_mask      <= csr_pwdata;
            CSR_FRAME_REG:          cfg_ff.frame_reg          <= csr_pwdata[7:0];
            CSR_STACK_REG:          cfg_ff.stack_reg          <= csr_pwdata[7:0];
            CSR_SLOT_SIZE:          cfg_ff.slot_size          <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_REGISTER_TOTAL:     csr_prdata = {57'd0, cfg_ff.register_total};
         CSR_SCRATCH_ORDER_LOW:  csr_prdata = cfg_ff.scratch_order_low;
         CSR_SCRATCH_ORDER_HIGH: csr_prdata = cfg_ff.scratch_order_high;
         CSR_SCRATCH_LENGTH:     csr_prdata = {59'd0, cfg_ff.scratch_length};
         CSR_RESERVED_MASK:      csr_prdata = cfg_ff.reserved_mask;
         CSR_FRAME_REG:          csr_prdata = {56'd0, cfg_ff.frame_reg};
         CSR_STACK_REG:          csr_prdata = {56'd0, cfg_ff.stack_reg};
         CSR_SLOT_SIZE:          csr_prdata = {56'd0, cfg_ff.slot_size};
         default:                csr_prdata = '0;
      endcase
   end

endmodule

// File: hw/rtl/register_pool_allocator.sv
// register pool allocator: keeps a busy bitmap over a pool of up to 64 registers
// and serves one request at a time. init, alloc specific, free, query, reserve and
// spill slot requests need no walk: the response is registered at the edge
// that accepts the request, so such requests can follow one another every cycle
// as long as responses are taken. alloc walks the configured scratch order list
// with a single shared in-range/free compare, one entry per cycle, over at most
// min(scratch_length, 16) entries, and still answers (a miss) for an empty list;
// req_ready stays low while the walk runs. configuration lives in eight 64-bit
// csr registers at byte address 8*i; write them only while no request is pending.
module register_pool_allocator import rpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // csr port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // sequencer states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   cfg_type cfg;

   rpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // state
   logic                 state_ff,    state_in;
   logic [MAX_REGS-1:0]  busy_ff,     busy_in;
   logic signed [31:0]   offset_ff,   offset_in;
   logic [15:0]          count_ff,    count_in;
   logic [SCR_IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // derived config
   logic [POOL_W-1:0]                      pool_size;
   logic [SCR_LEN_W-1:0]                   scan_len;
   logic [MAX_SCRATCH*SCR_ENTRY_W-1:0]     scratch_list;
   logic [SCR_ENTRY_W-1:0]                 scan_entry;
   logic                                   scan_hit;
   logic                                   scan_last;
   logic                                   req_fire;
   logic                                   req_in_pool;
   logic                                   req_busy;
   logic [MAX_REGS-1:0]                    req_bit;
   logic [MAX_REGS-1:0]                    init_range;
   logic [MAX_REGS-1:0]                    init_map;
   logic [7:0]                             slot_step;
   logic signed [32:0]                     offset_diff;

   // oversize settings clamp to the limits
   assign pool_size = (cfg.register_total > POOL_W'(MAX_REGS)) ? POOL_W'(MAX_REGS)
                                                               : cfg.register_total;
   assign scan_len  = (cfg.scratch_length > SCR_LEN_W'(MAX_SCRATCH)) ?
                      SCR_LEN_W'(MAX_SCRATCH) : cfg.scratch_length;

   assign scratch_list = {cfg.scratch_order_high, cfg.scratch_order_low};

   // shared compare: current scratch entry in range and free
   assign scan_entry = scratch_list[scan_idx_ff*SCR_ENTRY_W +: SCR_ENTRY_W];
   assign scan_hit   = (scan_entry < {1'b0, pool_size}) &&
                       !busy_ff[scan_entry[REG_IDX_W-1:0]];
   assign scan_last  = ({1'b0, scan_idx_ff} + SCR_LEN_W'(1)) >= scan_len;

   // single-register checks
   assign req_in_pool = req_data.reg_index < {1'b0, pool_size};
   assign req_bit     = MAX_REGS'(1) << req_data.reg_index[REG_IDX_W-1:0];
   assign req_busy    = busy_ff[req_data.reg_index[REG_IDX_W-1:0]];

   // init map: reserved bits inside the pool plus frame and stack registers
   assign init_range = (pool_size >= POOL_W'(MAX_REGS)) ? '1
                                                        : ((MAX_REGS'(1) << pool_size) - MAX_REGS'(1));

   always_comb begin
      init_map = cfg.reserved_mask & init_range;
      if (cfg.frame_reg < {1'b0, pool_size}) begin
         init_map = init_map | (MAX_REGS'(1) << cfg.frame_reg[REG_IDX_W-1:0]);
      end
      if (cfg.stack_reg < {1'b0, pool_size}) begin
         init_map = init_map | (MAX_REGS'(1) << cfg.stack_reg[REG_IDX_W-1:0]);
      end
   end

   // spill step, zero means the default slot size
   assign slot_step   = (cfg.slot_size == 8'd0) ? DEFAULT_SLOT : cfg.slot_size;
   assign offset_diff = {offset_ff[31], offset_ff} - $signed({25'd0, slot_step});

   // new requests only while idle and the response slot is free or draining
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      offset_in    = offset_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_data_in.success = 1'b0;
               rsp_data_in.reg_out = 8'd0;
               rsp_valid_in        = 1'b1;
               case (req_data.opcode)
                  OP_INIT: begin
                     busy_in             = init_map;
                     offset_in           = '0;
                     count_in            = '0;
                     rsp_data_in.success = 1'b1;
                  end
                  OP_ALLOC: begin
                     // result comes from the scan
                     rsp_valid_in = 1'b0;
                     scan_idx_in  = '0;
                     state_in     = S_SCAN;
                  end
                  OP_ALLOC_AT: begin
                     if (req_in_pool && !req_busy) begin
                        busy_in             = busy_ff | req_bit;
                        rsp_data_in.success = 1'b1;
                     end
                  end
                  OP_FREE: begin
                     // reserved and frame registers stay busy
                     if (req_in_pool &&
                         !cfg.reserved_mask[req_data.reg_index[REG_IDX_W-1:0]] &&
                         (req_data.reg_index != cfg.frame_reg)) begin
                        busy_in = busy_ff & ~req_bit;
                     end
                     rsp_data_in.success = 1'b1;
                  end
                  OP_QUERY: begin
                     rsp_data_in.success = req_in_pool && !req_busy;
                  end
                  OP_RESERVE: begin
                     if (req_in_pool) begin
                        busy_in = busy_ff | req_bit;
                     end
                     rsp_data_in.success = 1'b1;
                  end
                  OP_SPILL: begin
                     // saturate at the most negative offset
                     if (offset_diff[32] != offset_diff[31]) begin
                        offset_in = 32'sh8000_0000;
                     end else begin
                        offset_in = offset_diff[31:0];
                     end
                     if (count_ff != 16'hFFFF) begin
                        count_in = count_ff + 16'd1;
                     end
                     rsp_data_in.success = 1'b1;
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.slot_offset = offset_in;
               rsp_data_in.spill_total = count_in;
            end
         end
         S_SCAN: begin
            // response slot was freed before the scan started
            if (scan_len == '0) begin
               rsp_data_in.success = 1'b0;
               rsp_data_in.reg_out = 8'd0;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end else if (scan_hit) begin
               busy_in             = busy_ff | (MAX_REGS'(1) << scan_entry[REG_IDX_W-1:0]);
               rsp_data_in.success = 1'b1;
               rsp_data_in.reg_out = scan_entry;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end else if (scan_last) begin
               rsp_data_in.success = 1'b0;
               rsp_data_in.reg_out = 8'd0;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end else begin
               scan_idx_in = scan_idx_ff + SCR_IDX_W'(1);
            end
            rsp_data_in.slot_offset = offset_ff;
            rsp_data_in.spill_total = count_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         offset_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         offset_ff    <= offset_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
